### sv/first_fit_range_allocator_assert.svh
// Assertion macros for the first-fit range allocator.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FFRA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ffra assertion failed");
`define FFRA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ffra forbidden condition seen");
`else
`define FFRA_ASSERT(lbl, clk, rst_n, prop)
`define FFRA_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### sv/ffra_pkg.sv
// Types, constants and helpers shared by the first-fit range allocator.
package ffra_pkg;

  localparam int unsigned SizeW = 21;
  localparam int unsigned LocW  = 20;

  localparam logic [SizeW-1:0] SizeLimit    = 21'd1048576;
  localparam logic [SizeW-1:0] MinSizeReset = 21'd1024;

  localparam logic [1:0] CfgMinSize = 2'd0;
  localparam logic [1:0] CfgMaxSize = 2'd1;

  typedef enum logic [1:0] {
    ReqAlloc  = 2'd0,
    ReqFree   = 2'd1,
    ReqResize = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoRoom   = 2'd1,
    StNotFound = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [1:0]       buffer_id;
    logic [LocW-1:0]  location;
    logic [SizeW-1:0] cur_len;
    logic [SizeW-1:0] req_size;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [1:0]       buffer_id;
    logic [LocW-1:0]  location;
    logic [SizeW-1:0] capacity;
  } res_t;

  function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (v > SizeLimit) begin
      r = SizeLimit;
    end
    return r;
  endfunction

endpackage

### sv/ffra_core.sv
// Allocation engine: range table memory, per-buffer counts and the request sequencer.
`include "first_fit_range_allocator_assert.svh"
module ffra_core #(
  parameter int unsigned NUM_BUFFERS = 4,
  parameter int unsigned MAX_RANGES  = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  ffra_pkg::req_t             req_i,
  input  logic [ffra_pkg::SizeW-1:0] min_size_i,
  input  logic [ffra_pkg::SizeW-1:0] max_size_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output ffra_pkg::res_t             res_o
);
  import ffra_pkg::*;

  localparam int unsigned BW    = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned OW    = $clog2(NUM_BUFFERS + 1);
  localparam int unsigned CW    = $clog2(MAX_RANGES + 1);
  localparam int unsigned Depth = NUM_BUFFERS * MAX_RANGES;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned EW    = LocW + SizeW;
  localparam int unsigned PW    = SizeW + 1;
  localparam int unsigned GW    = SizeW + 2;

  typedef enum logic [3:0] {
    SIdle, SFindInit, SFind, SRemove, SAStart, SABuf, SAScan, SATail,
    SAGrow, SANew, SNGrow, SAFail, SRestore, SInsShift, SInsWrite, SDone
  } state_e;

  state_e           state_q, state_d;
  req_type_e        op_q, op_d;
  logic [SizeW-1:0] size_q, size_d, old_q, old_d;
  logic [LocW-1:0]  loc_q, loc_d;
  logic [BW-1:0]    cb_q, cb_d, ob_q, ob_d;
  logic [CW-1:0]    idx_q, idx_d, pos_q, pos_d;
  logic [PW-1:0]    prev_q, prev_d, used_q, used_d;
  logic [GW-1:0]    want_q, want_d, grown_q, grown_d;
  logic [LocW-1:0]  ins_start_q, ins_start_d;
  logic [SizeW-1:0] ins_len_q, ins_len_d;
  logic             rz_q, rz_d, restore_q, restore_d;
  res_t             res_q, res_d;
  logic [CW-1:0]    cnt_q [NUM_BUFFERS];
  logic [CW-1:0]    cnt_d [NUM_BUFFERS];
  logic [SizeW-1:0] cap_q [NUM_BUFFERS];
  logic [SizeW-1:0] cap_d [NUM_BUFFERS];
  logic [OW-1:0]    open_q, open_d;

  logic [EW-1:0]    mem [Depth];
  logic [EW-1:0]    rdata_q;
  logic             wr_en;
  logic [CW-1:0]    wr_idx;
  logic [EW-1:0]    wr_data;
  logic [AW-1:0]    rd_addr, wr_addr;

  logic [CW-1:0]    cnt_c;
  logic [SizeW-1:0] cap_c;
  logic [LocW-1:0]  e_start;
  logic [SizeW-1:0] e_len;
  logic [PW-1:0]    e_end;
  logic             ins_go, next_buf;
  logic [CW-1:0]    ins_pos;
  logic [LocW-1:0]  ins_start;
  logic [SizeW-1:0] ins_len;

  assign cnt_c   = cnt_q[cb_q];
  assign cap_c   = cap_q[cb_q];
  assign e_start = rdata_q[EW-1:SizeW];
  assign e_len   = rdata_q[SizeW-1:0];
  assign e_end   = PW'(e_start) + PW'(e_len);

  assign rd_addr = AW'(32'(cb_d) * MAX_RANGES + 32'(idx_d));
  assign wr_addr = AW'(32'(cb_q) * MAX_RANGES + 32'(wr_idx));

  assign req_ready_o = (state_q == SIdle);
  assign res_valid_o = (state_q == SDone);
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    size_d      = size_q;
    old_d       = old_q;
    loc_d       = loc_q;
    cb_d        = cb_q;
    ob_d        = ob_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    prev_d      = prev_q;
    used_d      = used_q;
    want_d      = want_q;
    grown_d     = grown_q;
    ins_start_d = ins_start_q;
    ins_len_d   = ins_len_q;
    rz_d        = rz_q;
    restore_d   = restore_q;
    res_d       = res_q;
    cnt_d       = cnt_q;
    cap_d       = cap_q;
    open_d      = open_q;
    wr_en       = 1'b0;
    wr_idx      = idx_q;
    wr_data     = rdata_q;
    ins_go      = 1'b0;
    next_buf    = 1'b0;
    ins_pos     = '0;
    ins_start   = '0;
    ins_len     = size_q;

    case (state_q)
      SIdle: begin
        if (req_valid_i) begin
          op_d      = req_type_e'(req_i.req_type);
          size_d    = req_i.req_size;
          old_d     = req_i.cur_len;
          loc_d     = req_i.location;
          rz_d      = 1'b0;
          restore_d = 1'b0;
          res_d        = '0;
          res_d.status = StNotFound;
          case (req_i.req_type)
            ReqAlloc: begin
              state_d = SAStart;
            end
            ReqFree, ReqResize: begin
              if (32'(req_i.buffer_id) < 32'(open_q)) begin
                cb_d    = BW'(req_i.buffer_id);
                ob_d    = BW'(req_i.buffer_id);
                state_d = SFindInit;
              end else begin
                state_d = SDone;
              end
            end
            default: begin
              state_d = SDone;
            end
          endcase
        end
      end
      SFindInit: begin
        if (cnt_c == '0) begin
          state_d = SDone;
        end else begin
          idx_d   = '0;
          state_d = SFind;
        end
      end
      SFind: begin
        if (e_start == loc_q && e_len == old_q) begin
          pos_d = idx_q;
          if (op_q == ReqResize && size_q <= old_q) begin
            wr_en       = 1'b1;
            wr_idx      = idx_q;
            wr_data     = {loc_q, size_q};
            res_d       = '{StOk, 2'(cb_q), loc_q, cap_c};
            state_d     = SDone;
          end else begin
            rz_d    = (op_q == ReqResize);
            idx_d   = idx_q + CW'(1);
            state_d = SRemove;
          end
        end else if (idx_q + CW'(1) < cnt_c) begin
          idx_d = idx_q + CW'(1);
        end else begin
          state_d = SDone;
        end
      end
      SRemove: begin
        if (idx_q < cnt_c) begin
          wr_en   = 1'b1;
          wr_idx  = idx_q - CW'(1);
          wr_data = rdata_q;
          idx_d   = idx_q + CW'(1);
        end else begin
          cnt_d[cb_q] = cnt_c - CW'(1);
          if (rz_q) begin
            state_d = SAStart;
          end else begin
            res_d   = '{StOk, 2'(cb_q), loc_q, cap_c};
            state_d = SDone;
          end
        end
      end
      SAStart: begin
        if (size_q > max_size_i) begin
          state_d = SAFail;
        end else if (open_q == '0) begin
          state_d = SANew;
        end else begin
          cb_d    = '0;
          state_d = SABuf;
        end
      end
      SABuf: begin
        prev_d = '0;
        if (32'(cnt_c) >= MAX_RANGES) begin
          next_buf = 1'b1;
        end else if (cnt_c == '0) begin
          used_d  = '0;
          want_d  = GW'(size_q);
          state_d = SATail;
        end else begin
          idx_d   = '0;
          state_d = SAScan;
        end
      end
      SAScan: begin
        if (PW'(e_start) >= prev_q && PW'(e_start) - prev_q >= PW'(size_q)) begin
          ins_go    = 1'b1;
          ins_pos   = idx_q;
          ins_start = LocW'(prev_q);
        end else begin
          prev_d = e_end;
          if (idx_q + CW'(1) < cnt_c) begin
            idx_d = idx_q + CW'(1);
          end else begin
            used_d  = e_end;
            want_d  = GW'(e_end) + GW'(size_q);
            state_d = SATail;
          end
        end
      end
      SATail: begin
        if (want_q <= GW'(cap_c)) begin
          ins_go    = 1'b1;
          ins_pos   = cnt_c;
          ins_start = LocW'(used_q);
        end else if (want_q > GW'(max_size_i) || cap_c > max_size_i || cap_c == '0) begin
          next_buf = 1'b1;
        end else begin
          grown_d = GW'(cap_c);
          state_d = SAGrow;
        end
      end
      SAGrow: begin
        if (grown_q < want_q) begin
          grown_d = grown_q << 1;
        end else begin
          cap_d[cb_q] = (grown_q > GW'(max_size_i)) ? max_size_i : SizeW'(grown_q);
          ins_go      = 1'b1;
          ins_pos     = cnt_c;
          ins_start   = LocW'(used_q);
        end
      end
      SANew: begin
        if (32'(open_q) >= NUM_BUFFERS) begin
          state_d = SAFail;
        end else begin
          cb_d    = BW'(open_q);
          grown_d = GW'(min_size_i);
          state_d = SNGrow;
        end
      end
      SNGrow: begin
        if (grown_q < GW'(size_q)) begin
          grown_d = grown_q << 1;
        end else begin
          cap_d[cb_q] = (grown_q > GW'(max_size_i)) ? max_size_i : SizeW'(grown_q);
          cnt_d[cb_q] = '0;
          open_d      = open_q + OW'(1);
          ins_go      = 1'b1;
        end
      end
      SAFail: begin
        if (rz_q) begin
          cb_d      = ob_q;
          restore_d = 1'b1;
          state_d   = SRestore;
        end else begin
          res_d        = '0;
          res_d.status = StNoRoom;
          state_d      = SDone;
        end
      end
      SRestore: begin
        ins_go    = 1'b1;
        ins_pos   = pos_q;
        ins_start = loc_q;
        ins_len   = old_q;
      end
      SInsShift: begin
        wr_en   = 1'b1;
        wr_idx  = idx_q + CW'(1);
        wr_data = rdata_q;
        if (idx_q > pos_q) begin
          idx_d = idx_q - CW'(1);
        end else begin
          state_d = SInsWrite;
        end
      end
      SInsWrite: begin
        wr_en       = 1'b1;
        wr_idx      = pos_q;
        wr_data     = {ins_start_q, ins_len_q};
        cnt_d[cb_q] = cnt_c + CW'(1);
        if (restore_q) begin
          res_d = '{StNoRoom, 2'(cb_q), loc_q, cap_c};
        end else begin
          res_d = '{StOk, 2'(cb_q), ins_start_q, cap_c};
        end
        state_d = SDone;
      end
      SDone: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    if (ins_go) begin
      pos_d       = ins_pos;
      ins_start_d = ins_start;
      ins_len_d   = ins_len;
      if (cnt_c > ins_pos) begin
        idx_d   = cnt_c - CW'(1);
        state_d = SInsShift;
      end else begin
        state_d = SInsWrite;
      end
    end

    if (next_buf) begin
      if (32'(cb_q) + 32'd1 < 32'(open_q)) begin
        cb_d    = cb_q + BW'(1);
        state_d = SABuf;
      end else begin
        state_d = SANew;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      open_q  <= '0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        cnt_q[i] <= '0;
        cap_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      cnt_q   <= cnt_d;
      cap_q   <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    size_q      <= size_d;
    old_q       <= old_d;
    loc_q       <= loc_d;
    cb_q        <= cb_d;
    ob_q        <= ob_d;
    idx_q       <= idx_d;
    pos_q       <= pos_d;
    prev_q      <= prev_d;
    used_q      <= used_d;
    want_q      <= want_d;
    grown_q     <= grown_d;
    ins_start_q <= ins_start_d;
    ins_len_q   <= ins_len_d;
    rz_q        <= rz_d;
    restore_q   <= restore_d;
    res_q       <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  `FFRA_ASSERT_NEVER(a_open_bound, clk_i, rst_ni, 32'(open_q) > NUM_BUFFERS)
  `FFRA_ASSERT(a_busy_after_accept, clk_i, rst_ni, (req_valid_i && req_ready_o) |=> !req_ready_o)
  `FFRA_ASSERT(a_grow_nonzero, clk_i, rst_ni, (state_q == SAGrow || state_q == SNGrow) |-> (grown_q != '0))
  `FFRA_ASSERT(a_insert_room, clk_i, rst_ni, (state_q == SInsWrite) |-> (32'(cnt_q[cb_q]) < MAX_RANGES))

endmodule

### sv/first_fit_range_allocator.sv
// Top level of the first-fit range allocator: configuration, engine and output register.
// One request is worked at a time. A request sweeps the range tables of the open buffers
// through a table memory with one read and one write port at one entry per cycle; an
// allocate also doubles a buffer's capacity as needed and shifts the entries behind the
// insert point (up to MAX_RANGES - 1). A free or a growing resize first searches one
// buffer's table and shifts entries to close the gap; a shrinking resize is written in
// place. A free or resize that names a buffer not yet open goes straight to its result.
// A finished result sits in the output register, so the next request is taken while it
// waits. No memory clearing is needed after reset.
module first_fit_range_allocator #(
  parameter int unsigned NUM_BUFFERS = 4,
  parameter int unsigned MAX_RANGES  = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 req_type_i,
  input  logic [1:0]                 buffer_id_i,
  input  logic [ffra_pkg::LocW-1:0]  location_i,
  input  logic [ffra_pkg::SizeW-1:0] cur_len_i,
  input  logic [ffra_pkg::SizeW-1:0] req_size_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [1:0]                 out_buffer_id_o,
  output logic [ffra_pkg::LocW-1:0]  out_location_o,
  output logic [ffra_pkg::SizeW-1:0] out_capacity_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [ffra_pkg::SizeW-1:0] cfg_data_i
);
  import ffra_pkg::*;

  logic [SizeW-1:0] min_size_q, max_size_q;
  req_t             req;
  res_t             core_res, out_q;
  logic             core_res_valid, out_free, out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q <= MinSizeReset;
      max_size_q <= SizeLimit;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMinSize: min_size_q <= clamp_size(cfg_data_i);
        CfgMaxSize: max_size_q <= clamp_size(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  assign req = '{req_type_i, buffer_id_i, location_i, cur_len_i, req_size_i};

  ffra_core #(
    .NUM_BUFFERS(NUM_BUFFERS),
    .MAX_RANGES (MAX_RANGES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_ready_o(in_ready_o),
    .req_i      (req),
    .min_size_i (min_size_q),
    .max_size_i (max_size_q),
    .res_valid_o(core_res_valid),
    .res_ready_i(out_free),
    .res_o      (core_res)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= core_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && core_res_valid) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign out_buffer_id_o = out_q.buffer_id;
  assign out_location_o  = out_q.location;
  assign out_capacity_o  = out_q.capacity;

endmodule
